>>> src/tks_pkg.sv
`default_nettype none
package tks_pkg;

   // Field widths fixed by the item layout.
   localparam int SCORE_W = 32;
   localparam int TAG_W   = 16;
   localparam int KIND_W  = 2;
   localparam int RANK_W  = 4;
   localparam int LIM_W   = 5;

   // Build depth default and the hard ceiling on ranked entries.
   localparam int DEPTH_DEF = 16;
   localparam int MAX_SLOTS = 16;
   localparam logic [LIM_W-1:0] SLOTS_RESET = 5'd16;

   // Input item kinds.
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   // One stored entry of the list.
   typedef struct packed {
      logic                      valid;
      logic signed [SCORE_W-1:0] score;
      logic        [TAG_W-1:0]   tag;
   } tks_entry_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic clear_all;  // drop the valid bit
      logic trim;       // drop the valid bit if outside the window
      logic ins_en;     // an accepted insert moves through the row this cycle
      logic in_window;  // cell index is below the effective limit
   } tks_ctrl_type;

endpackage
`default_nettype wire

>>> src/tks_cell.sv
`default_nettype none
module tks_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  tks_pkg::tks_ctrl_type       ctrl,
   input  wire  signed [31:0]          cand_score,
   input  wire         [15:0]          cand_tag,
   input  tks_pkg::tks_entry_type      prev_entry,
   input  wire                         prev_keep,
   output tks_pkg::tks_entry_type      entry,
   output logic                        keep
);
   import tks_pkg::*;

   tks_entry_type entry_ff;
   tks_entry_type entry_in;

   // The cell keeps its place when it holds an entry that ranks at or above
   // the candidate.
   assign keep  = entry_ff.valid && (entry_ff.score >= cand_score);
   assign entry = entry_ff;

   // Clear or trim the valid bit, hold, take the candidate, or take the neighbor's entry one rank up.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.clear_all) begin
         entry_in.valid = 1'b0;
      end else if (ctrl.trim && !ctrl.in_window) begin
         entry_in.valid = 1'b0;
      end else if (ctrl.ins_en && ctrl.in_window && !keep) begin
         if (prev_keep) begin
            entry_in.valid = 1'b1;
            entry_in.score = cand_score;
            entry_in.tag   = cand_tag;
         end else begin
            entry_in = prev_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.score <= entry_in.score;
      entry_ff.tag   <= entry_in.tag;
   end

endmodule
`default_nettype wire

>>> src/top_k_score_insertion.sv
`default_nettype none
// Sorted top-k list built as a row of cells, one entry per cell.
// Insert: the item is registered and the sequencer moves to the insert state, where the compare-and-shift
// step updates the row of cells and fills the result register once it is free; no new item is taken before that.
// Read-out: results come from the read state, one result per cycle while the result register is free (rsp_tready).
// Clear and unused kinds give no result.
// Synchronous reset drops all valid bits at once and sets the limit to 16.
module top_k_score_insertion #(
   parameter int DEPTH = tks_pkg::DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   // Input items.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,   // score[31:0], tag[47:32]
   input  wire  [1:0]  req_tuser,   // kind[1:0]
   // Result items.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata,   // rank[3:0], out_score[35:4], out_tag[51:36], zero
   output logic [1:0]  rsp_tuser,   // entry_valid[0], accepted[1]
   output logic        rsp_tlast,
   // Configuration.
   input  wire         csr_wr_en,
   input  wire  [4:0]  csr_wr_data
);
   import tks_pkg::*;

   localparam int CAP = (DEPTH < MAX_SLOTS) ? DEPTH : MAX_SLOTS;
   localparam int KW  = (CAP > 1) ? $clog2(CAP) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_INS  = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   function automatic logic [LIM_W-1:0] eff_limit(input logic [LIM_W-1:0] v);
      logic [LIM_W-1:0] r;
      r = v;
      if (r == '0) r = LIM_W'(1);
      if (r > LIM_W'(CAP)) r = LIM_W'(CAP);
      return r;
   endfunction

   logic [1:0]           state_ff, state_in;
   logic [LIM_W-1:0]     slots_ff;
   logic [KW-1:0]        rd_idx_ff, rd_idx_in;
   logic signed [SCORE_W-1:0] cand_score_ff;
   logic [TAG_W-1:0]     cand_tag_ff;

   logic                 out_vld_ff, out_vld_in;
   logic                 out_ev_ff, out_ev_in;
   logic                 out_acc_ff, out_acc_in;
   logic [RANK_W-1:0]    out_rank_ff, out_rank_in;
   logic [SCORE_W-1:0]   out_score_ff, out_score_in;
   logic [TAG_W-1:0]     out_tag_ff, out_tag_in;
   logic                 out_last_ff, out_last_in;

   logic [LIM_W-1:0]     lim;
   logic [LIM_W-1:0]     win_lim;
   logic [LIM_W-1:0]     pos;
   logic                 reject;
   logic                 out_free;
   logic                 req_take;
   logic                 clear_all;
   logic                 ins_go;

   tks_entry_type        ent [DEPTH];
   logic [DEPTH-1:0]     keep_vec;
   logic [CAP-1:0]       nxt_vld;
   tks_entry_type        rd_ent;
   logic                 rd_last;

   assign lim     = eff_limit(slots_ff);
   assign win_lim = csr_wr_en ? eff_limit(csr_wr_data) : lim;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !out_vld_ff || rsp_tready;
   assign clear_all  = req_take && (req_tuser == KIND_CLEAR);

   // Insert position: keep bits form a prefix, so their count is the rank.
   always_comb begin
      pos = '0;
      for (int i = 0; i < CAP; i++) begin
         pos = pos + LIM_W'(keep_vec[i]);
      end
   end
   assign reject = (pos >= lim);
   assign ins_go = (state_ff == ST_INS) && out_free && !reject;

   // Row of cells.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      tks_ctrl_type  ctrl;
      tks_entry_type prev_entry;
      logic          prev_keep;

      assign ctrl.clear_all = clear_all;
      assign ctrl.trim      = csr_wr_en;
      assign ctrl.ins_en    = ins_go;
      assign ctrl.in_window = (g < CAP) && (LIM_W'(g) < win_lim);

      if (g == 0) begin : g_head
         assign prev_entry = '0;
         assign prev_keep  = 1'b1;
      end else begin : g_body
         assign prev_entry = ent[g-1];
         assign prev_keep  = keep_vec[g-1];
      end

      tks_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cand_score (cand_score_ff),
         .cand_tag   (cand_tag_ff),
         .prev_entry (prev_entry),
         .prev_keep  (prev_keep),
         .entry      (ent[g]),
         .keep       (keep_vec[g])
      );
   end

   // Valid bit of the entry one rank below each read position.
   for (genvar g = 0; g < CAP; g++) begin : g_nxt
      if (g + 1 < CAP) begin : g_mid
         assign nxt_vld[g] = ent[g+1].valid;
      end else begin : g_end
         assign nxt_vld[g] = 1'b0;
      end
   end

   assign rd_ent  = ent[rd_idx_ff];
   assign rd_last = ((LIM_W'(rd_idx_ff) + LIM_W'(1)) >= lim) || !nxt_vld[rd_idx_ff];

   // Sequencer and result register.
   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      out_vld_in   = out_vld_ff && !rsp_tready;
      out_ev_in    = out_ev_ff;
      out_acc_in   = out_acc_ff;
      out_rank_in  = out_rank_ff;
      out_score_in = out_score_ff;
      out_tag_in   = out_tag_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_tuser)
                  KIND_INSERT: state_in = ST_INS;
                  KIND_READ: begin
                     state_in  = ST_READ;
                     rd_idx_in = '0;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_last_in = 1'b1;
               if (reject) begin
                  out_ev_in    = 1'b0;
                  out_acc_in   = 1'b0;
                  out_rank_in  = '0;
                  out_score_in = '0;
                  out_tag_in   = '0;
               end else begin
                  out_ev_in    = 1'b1;
                  out_acc_in   = 1'b1;
                  out_rank_in  = pos[RANK_W-1:0];
                  out_score_in = cand_score_ff;
                  out_tag_in   = cand_tag_ff;
               end
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_acc_in = 1'b0;
               if (!rd_ent.valid) begin
                  // Empty list: a single invalid result.
                  out_ev_in    = 1'b0;
                  out_rank_in  = '0;
                  out_score_in = '0;
                  out_tag_in   = '0;
                  out_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  out_ev_in    = 1'b1;
                  out_rank_in  = RANK_W'(rd_idx_ff);
                  out_score_in = rd_ent.score;
                  out_tag_in   = rd_ent.tag;
                  out_last_in  = rd_last;
                  if (rd_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     rd_idx_in = rd_idx_ff + KW'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         slots_ff   <= SLOTS_RESET;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         if (csr_wr_en) begin
            slots_ff <= csr_wr_data;
         end
      end
      rd_idx_ff    <= rd_idx_in;
      out_ev_ff    <= out_ev_in;
      out_acc_ff   <= out_acc_in;
      out_rank_ff  <= out_rank_in;
      out_score_ff <= out_score_in;
      out_tag_ff   <= out_tag_in;
      out_last_ff  <= out_last_in;
      if (req_take) begin
         cand_score_ff <= req_tdata[31:0];
         cand_tag_ff   <= req_tdata[47:32];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'b0000, out_tag_ff, out_score_ff, out_rank_ff};
   assign rsp_tuser  = {out_acc_ff, out_ev_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire
